// File: rtl/mrwt_pkg.sv
// Package for the Miller-Rabin witness test block.
// Holds the controller-to-datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package mrwt_pkg;

   // Datapath operations issued by the controller.
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1; // latch n, a; init r = 1, p = a
   localparam logic [2:0] OP_MSTART = 3'd3; // start a modular multiply
   localparam logic [2:0] OP_MSTEP  = 3'd4; // one bit of the modular multiply
   localparam logic [2:0] OP_SHIFT  = 3'd5; // strip one trailing zero of n-1
   localparam logic [2:0] OP_ESHIFT = 3'd6; // e >>= 1, or s counts down when sel is MUL_BB

   // Multiply destination selects.
   localparam logic [1:0] MUL_RP  = 2'd0; // r = r * p
   localparam logic [1:0] MUL_PP  = 2'd1; // p = p * p
   localparam logic [1:0] MUL_BB  = 2'd2; // r = r * r (squaring phase)
   localparam logic [1:0] MUL_RED = 2'd3; // p = 1 * p, reduces the witness mod n

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic n_is_two;
      logic n_trivial;   // even or below three
      logic t_odd;       // trailing zeros removed
      logic e_zero;
      logic e_lsb;
      logic mul_done;
      logic r_is_one;
      logic r_is_nm1;
      logic s_zero;
   } status_type;

endpackage

// File: rtl/mrwt_if.sv
// Valid/ready channel interface used by the request and response ports.
// Depends on nothing.
`timescale 1ns / 1ps
interface mrwt_if #(parameter int DW = 1);
   logic          valid;
   logic          ready;
   logic [DW-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mrwt_datapath.sv
// Datapath: operand registers, shift-and-add modular multiplier, exponent.
// Depends on mrwt_pkg.
`timescale 1ns / 1ps
module mrwt_datapath #(
   parameter int WIDTH = 64
) (
   input  logic                 clock,
   input  logic [WIDTH-1:0]     n_in_data,
   input  logic [WIDTH-1:0]     a_in_data,
   input  mrwt_pkg::cmd_type    cmd,
   output mrwt_pkg::status_type status
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] n_ff, n_in, r_ff, r_in, p_ff, p_in, e_ff, e_in;
   logic [WIDTH-1:0] acc_ff, acc_in, x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]    s_ff, s_in, cnt_ff, cnt_in;
   logic [WIDTH-1:0] nm1, dbl, sum;

   assign nm1 = n_ff - WIDTH'(1);

   // add_mod helper: (u + v) mod n with u, v below n.
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] u,
                                               input logic [WIDTH-1:0] v,
                                               input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] room;
      room = m - v;
      add_mod = (u >= room) ? u - room : u + v;
   endfunction

   assign dbl = add_mod(acc_ff, acc_ff, n_ff);
   assign sum = y_ff[WIDTH-1] ? add_mod(dbl, x_ff, n_ff) : dbl;

   always_comb begin
      n_in   = n_ff;
      r_in   = r_ff;
      p_in   = p_ff;
      e_in   = e_ff;
      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      s_in   = s_ff;
      cnt_in = cnt_ff;
      case (cmd.op)
         mrwt_pkg::OP_LOAD: begin
            n_in = n_in_data;
            p_in = a_in_data;
            r_in = WIDTH'(1);
            e_in = n_in_data - WIDTH'(1);
            s_in = '0;
         end
         mrwt_pkg::OP_SHIFT: begin
            e_in = e_ff >> 1;
            s_in = s_ff + CW'(1);
         end
         mrwt_pkg::OP_ESHIFT: begin
            if (cmd.sel == mrwt_pkg::MUL_BB) begin
               s_in = s_ff - CW'(1);
            end else begin
               e_in = e_ff >> 1;
            end
         end
         mrwt_pkg::OP_MSTART: begin
            acc_in = '0;
            cnt_in = CW'(WIDTH);
            case (cmd.sel)
               mrwt_pkg::MUL_RP:  begin x_in = r_ff; y_in = p_ff; end
               mrwt_pkg::MUL_PP:  begin x_in = p_ff; y_in = p_ff; end
               // Multiplying the raw witness by one leaves a mod n.
               mrwt_pkg::MUL_RED: begin x_in = WIDTH'(1); y_in = p_ff; end
               default:           begin x_in = r_ff; y_in = r_ff; end
            endcase
         end
         mrwt_pkg::OP_MSTEP: begin
            acc_in = sum;
            y_in   = y_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               if (cmd.sel == mrwt_pkg::MUL_PP || cmd.sel == mrwt_pkg::MUL_RED) begin
                  p_in = sum;
               end else begin
                  r_in = sum;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      r_ff   <= r_in;
      p_ff   <= p_in;
      e_ff   <= e_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      s_ff   <= s_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      status.n_is_two  = (n_ff == WIDTH'(2));
      status.n_trivial = (n_ff < WIDTH'(3)) || !n_ff[0];
      status.t_odd     = e_ff[0];
      status.e_zero    = (e_ff == '0);
      status.e_lsb     = e_ff[0];
      status.mul_done  = (cnt_ff == CW'(1));
      status.r_is_one  = (r_ff == WIDTH'(1));
      status.r_is_nm1  = (r_ff == nm1);
      status.s_zero    = (s_ff == '0);
   end
endmodule

// File: rtl/mrwt_ctrl.sv
// Controller state machine sequencing the witness test over the datapath.
// Depends on mrwt_pkg.
`timescale 1ns / 1ps
module mrwt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_go,
   output logic                 req_take,
   input  logic                 rsp_take,
   output logic                 rsp_full,
   output logic                 rsp_bit,
   output mrwt_pkg::cmd_type    cmd,
   input  mrwt_pkg::status_type status
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_REDUCE = 4'd2;
   localparam logic [3:0] S_SPLIT  = 4'd3;
   localparam logic [3:0] S_EXP    = 4'd4;
   localparam logic [3:0] S_MRP    = 4'd5;
   localparam logic [3:0] S_MPP    = 4'd6;
   localparam logic [3:0] S_ESHIFT = 4'd7;
   localparam logic [3:0] S_TEST   = 4'd8;
   localparam logic [3:0] S_MBB    = 4'd9;
   localparam logic [3:0] S_SDEC   = 4'd10;
   localparam logic [3:0] S_START  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] msel_ff, msel_in;
   logic       full_ff, full_in, res_ff, res_in;
   logic       done;
   logic       verdict;

   assign req_take = (state_ff == S_IDLE) && (!full_ff || rsp_take);
   assign rsp_full = full_ff;
   assign rsp_bit  = res_ff;

   always_comb begin
      state_in = state_ff;
      msel_in  = msel_ff;
      cmd.op   = mrwt_pkg::OP_NONE;
      cmd.sel  = msel_ff;
      done     = 1'b0;
      verdict  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_go && req_take) begin
               cmd.op   = mrwt_pkg::OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.n_is_two) begin
               done = 1'b1; verdict = 1'b1;
            end else if (status.n_trivial) begin
               done = 1'b1;
            end else begin
               cmd.op = mrwt_pkg::OP_MSTART; cmd.sel = mrwt_pkg::MUL_RED;
               msel_in = mrwt_pkg::MUL_RED; state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            // The witness is reduced mod n by one pass of the multiplier.
            cmd.op = mrwt_pkg::OP_MSTEP;
            if (status.mul_done) state_in = S_SPLIT;
         end
         S_SPLIT: begin
            if (status.t_odd) begin
               state_in = S_EXP;
            end else begin
               cmd.op = mrwt_pkg::OP_SHIFT;
            end
         end
         S_EXP: begin
            if (status.e_zero) begin
               // b equal to one before any squaring means probably prime.
               if (status.r_is_one) begin
                  done = 1'b1; verdict = 1'b1;
               end else begin
                  state_in = S_TEST;
               end
            end else if (status.e_lsb) begin
               cmd.op = mrwt_pkg::OP_MSTART; cmd.sel = mrwt_pkg::MUL_RP;
               msel_in = mrwt_pkg::MUL_RP; state_in = S_MRP;
            end else begin
               cmd.op = mrwt_pkg::OP_MSTART; cmd.sel = mrwt_pkg::MUL_PP;
               msel_in = mrwt_pkg::MUL_PP; state_in = S_MPP;
            end
         end
         S_MRP: begin
            cmd.op = mrwt_pkg::OP_MSTEP;
            if (status.mul_done) state_in = S_START;
         end
         S_START: begin
            cmd.op = mrwt_pkg::OP_MSTART; cmd.sel = mrwt_pkg::MUL_PP;
            msel_in = mrwt_pkg::MUL_PP; state_in = S_MPP;
         end
         S_MPP: begin
            cmd.op = mrwt_pkg::OP_MSTEP;
            if (status.mul_done) state_in = S_ESHIFT;
         end
         S_ESHIFT: begin
            cmd.op = mrwt_pkg::OP_ESHIFT; cmd.sel = mrwt_pkg::MUL_PP;
            state_in = S_EXP;
         end
         S_TEST: begin
            // Reaching one by squaring without passing n-1 means composite.
            if (status.s_zero) begin
               done = 1'b1;
            end else if (status.r_is_nm1) begin
               done = 1'b1; verdict = 1'b1;
            end else if (status.r_is_one) begin
               done = 1'b1;
            end else begin
               cmd.op = mrwt_pkg::OP_MSTART; cmd.sel = mrwt_pkg::MUL_BB;
               msel_in = mrwt_pkg::MUL_BB; state_in = S_MBB;
            end
         end
         S_MBB: begin
            cmd.op = mrwt_pkg::OP_MSTEP;
            if (status.mul_done) state_in = S_SDEC;
         end
         S_SDEC: begin
            cmd.op = mrwt_pkg::OP_ESHIFT; cmd.sel = mrwt_pkg::MUL_BB;
            state_in = S_TEST;
         end
         default: state_in = S_IDLE;
      endcase
      if (done) state_in = S_IDLE;
   end

   always_comb begin
      full_in = full_ff;
      res_in  = res_ff;
      if (rsp_take) full_in = 1'b0;
      if (done) begin
         full_in = 1'b1;
         res_in  = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         msel_ff  <= mrwt_pkg::MUL_RP;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         msel_ff  <= msel_in;
         full_ff  <= full_in;
      end
      res_ff <= res_in;
   end
endmodule

// File: rtl/miller_rabin_witness_test_top.sv
// Top level of the Miller-Rabin witness test.
// Depends on mrwt_pkg, mrwt_if, mrwt_ctrl and mrwt_datapath.
//
// Usage: a request on req carries the candidate n and witness a; one
// response on rsp carries the probably_prime flag. n equal to 2 is prime;
// even n and n below three are composite. Otherwise the witness is first
// reduced mod n by one pass of the shift-and-add multiplier, n-1 is split
// into 2^s times odd t one bit a cycle, and a^t mod n is formed by
// square-and-multiply, followed by up to s squarings. The modular multiplier
// is the unit that sets the rate.
// One request is in work at a time. The response sits in an output
// register; a new request is taken while it waits only when the result is
// being taken in the same cycle. A stalled receiver holds rsp valid and
// blocks further requests. Reset (synchronous) empties the block.
`timescale 1ns / 1ps
module miller_rabin_witness_test_top #(
   parameter int WIDTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   mrwt_if.sink       req_chan,
   mrwt_if.source     rsp_chan
);
   mrwt_pkg::cmd_type    cmd;
   mrwt_pkg::status_type status;
   logic                 rsp_full, rsp_bit;

   // Request payload: candidate in the low WIDTH bits, witness from bit 64 up.
   mrwt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_go   (req_chan.valid),
      .req_take (req_chan.ready),
      .rsp_take (rsp_chan.ready),
      .rsp_full (rsp_full),
      .rsp_bit  (rsp_bit),
      .cmd      (cmd),
      .status   (status)
   );

   mrwt_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock     (clock),
      .n_in_data (req_chan.data[WIDTH-1:0]),
      .a_in_data (req_chan.data[64+WIDTH-1:64]),
      .cmd       (cmd),
      .status    (status)
   );

   assign rsp_chan.valid = rsp_full;
   assign rsp_chan.data  = rsp_bit;
endmodule
